// ----- rtl/core/eiw_pkg.sv -----
// shared types, constants and clamp helper for the 2d euler integrator
package eiw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int MASS_W        = 31;
  localparam int DT_W          = 17;
  localparam int SPEED_W       = 17;
  localparam int SIZE_W        = 31;
  localparam int LANES         = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_TDATA_W    = 240;
  localparam int OUT_TDATA_W   = 192;

  // register reset values, q16.16
  localparam logic [DATA_W-1:0]  GRAVITY_X_RST     = 32'd0;
  localparam logic [DATA_W-1:0]  GRAVITY_Y_RST     = 32'd642908;
  localparam logic [SIZE_W-1:0]  SCREEN_WIDTH_RST  = 31'd125829120;
  localparam logic [SIZE_W-1:0]  SCREEN_HEIGHT_RST = 31'd70778880;
  localparam logic [SPEED_W-1:0] REST_SPEED_RST    = 17'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY_X     = 3'd0,
    REG_GRAVITY_Y     = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_REST_SPEED    = 3'd4
  } cfg_idx_t;

  // body payload that travels along the pipeline, lane 0 is x, lane 1 is y
  typedef struct packed {
    logic [LANES-1:0][DATA_W-1:0] pos;
    logic [LANES-1:0][DATA_W-1:0] vel;
    logic [LANES-1:0][DATA_W-1:0] frc;
    logic [MASS_W-1:0]            mass;
    logic [DT_W-1:0]              dt;
    logic                         sat;
  } body_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } sat32_t;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  function automatic sat32_t sat32(input logic signed [63:0] v);
    sat32_t r;
    if (v > S32_MAX) begin
      r.sat = 1'b1;
      r.val = S32_MAX[DATA_W-1:0];
    end else if (v < S32_MIN) begin
      r.sat = 1'b1;
      r.val = S32_MIN[DATA_W-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/euler_integrator_wrap_2d_core.sv -----
// semi-implicit euler integrator for one 2d body per cycle, with screen wrap and rest test
// path from input transfer to out_tvalid: s1 to s4, the divider, then sa, sb, sc, sd, se and sf
// throughput: one body per cycle; the force/mass divider is a 32+FRAC_BITS stage pipeline
// flow control: one global stage enable, the whole pipe holds while the output waits
// reset (rst_n low, synchronous): all stage valid bits cleared, config registers to defaults
// config writes are always taken (cfg_ready high) and must only happen while the pipe is empty
module euler_integrator_wrap_2d_core #(
  parameter int FRAC_BITS = eiw_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input body: pos_x, pos_y, vel_x, vel_y, force_x, force_y (32 each),
  // body_mass (31), time_step (17)
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [eiw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result: new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_force_x, new_force_y (32 each)
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [eiw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // result flag: saturated
  output logic [0:0]                         out_tuser,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [eiw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eiw_pkg::DATA_W-1:0]         cfg_data
);
  import eiw_pkg::*;

  localparam int N_W   = DATA_W + FRAC_BITS;
  localparam int TAG_W = $bits(body_t);
  localparam int PA_W  = DATA_W + DT_W + 1;   // signed value times unsigned step
  localparam int SQ_W  = 2 * DATA_W;
  localparam int RR_W  = 2 * SPEED_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][DATA_W-1:0] grav_r;
  logic [LANES-1:0][SIZE_W-1:0] size_r;
  logic [SPEED_W-1:0]           rest_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r[0] <= GRAVITY_X_RST;
      grav_r[1] <= GRAVITY_Y_RST;
      size_r[0] <= SCREEN_WIDTH_RST;
      size_r[1] <= SCREEN_HEIGHT_RST;
      rest_r    <= REST_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GRAVITY_X:     grav_r[0] <= cfg_data;
        REG_GRAVITY_Y:     grav_r[1] <= cfg_data;
        REG_SCREEN_WIDTH:  size_r[0] <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: size_r[1] <= cfg_data[SIZE_W-1:0];
        REG_REST_SPEED:    rest_r    <= cfg_data[SPEED_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // global stage enable: advance unless the output register holds an untaken result
  // ---------------------------------------------------------------------------
  logic en;
  logic vf_r;

  assign en        = !vf_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // s1: input register
  // ---------------------------------------------------------------------------
  logic  v1_r;
  body_t t1_r, t1_nxt;

  always_comb begin
    t1_nxt.pos[0] = in_tdata[31:0];
    t1_nxt.pos[1] = in_tdata[63:32];
    t1_nxt.vel[0] = in_tdata[95:64];
    t1_nxt.vel[1] = in_tdata[127:96];
    t1_nxt.frc[0] = in_tdata[159:128];
    t1_nxt.frc[1] = in_tdata[191:160];
    t1_nxt.mass   = in_tdata[222:192];
    t1_nxt.dt     = in_tdata[239:223];
    t1_nxt.sat    = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // s2: gravity times mass, full width
  // ---------------------------------------------------------------------------
  logic                                 v2_r;
  body_t                                t2_r;
  logic [LANES-1:0][2*DATA_W-1:0]       gm2_r, gm2_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      gm2_nxt[i] = 64'($signed(grav_r[i])) * 64'($signed({1'b0, t1_r.mass}));
    end
  end

  // ---------------------------------------------------------------------------
  // s3: drop the fraction (floor) and clamp
  // ---------------------------------------------------------------------------
  logic                         v3_r;
  body_t                        t3_r, t3_nxt;
  logic [LANES-1:0][DATA_W-1:0] gm3_r, gm3_nxt;

  always_comb begin
    sat32_t c;
    t3_nxt = t2_r;
    for (int i = 0; i < LANES; i++) begin
      c          = sat32($signed(gm2_r[i]) >>> FRAC_BITS);
      gm3_nxt[i] = c.val;
      t3_nxt.sat = t3_nxt.sat | c.sat;
    end
  end

  // ---------------------------------------------------------------------------
  // s4: force plus gravity term, clamped
  // ---------------------------------------------------------------------------
  logic  v4_r;
  body_t t4_r, t4_nxt;

  always_comb begin
    sat32_t            c;
    logic signed [63:0] f64;
    logic signed [63:0] g64;
    t4_nxt = t3_r;
    for (int i = 0; i < LANES; i++) begin
      f64           = 64'($signed(t3_r.frc[i]));
      g64           = 64'($signed(gm3_r[i]));
      c             = sat32(f64 + g64);
      t4_nxt.frc[i] = c.val;
      t4_nxt.sat    = t4_nxt.sat | c.sat;
    end
  end

  // ---------------------------------------------------------------------------
  // divider: |force| * 2^FRAC_BITS / mass, one quotient bit per stage
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][DATA_W-1:0] mag4;
  logic                         vdv;
  logic [LANES-1:0][N_W-1:0]    quo;
  logic [TAG_W-1:0]             tdv_raw;
  body_t                        tdv;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag4[i] = t4_r.frc[i][DATA_W-1] ? DATA_W'(-$signed(t4_r.frc[i])) : t4_r.frc[i];
    end
  end

  eiw_div #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_mag    (mag4),
    .in_div    (t4_r.mass),
    .in_tag    (t4_r),
    .out_valid (vdv),
    .out_quo   (quo),
    .out_tag   (tdv_raw)
  );

  assign tdv = body_t'(tdv_raw);

  // ---------------------------------------------------------------------------
  // sa: signed acceleration with clamp, zero mass gives zero for a zero force and else saturates toward the force sign
  // ---------------------------------------------------------------------------
  logic                         va_r;
  body_t                        ta_r, ta_nxt;
  logic [LANES-1:0][DATA_W-1:0] acc_r, acc_nxt;

  always_comb begin
    logic       neg;
    logic       fzero;
    logic       pos_ovf;
    logic       neg_ovf;
    logic [DATA_W:0] negq;
    ta_nxt = tdv;
    for (int i = 0; i < LANES; i++) begin
      neg     = tdv.frc[i][DATA_W-1];
      fzero   = (tdv.frc[i] == '0);
      pos_ovf = |quo[i][N_W-1:DATA_W-1];
      neg_ovf = (|quo[i][N_W-1:DATA_W]) || (quo[i][DATA_W-1] && (|quo[i][DATA_W-2:0]));
      negq    = (DATA_W+1)'(-$signed({1'b0, quo[i][DATA_W-1:0]}));
      if (tdv.mass == '0) begin
        if (fzero) begin
          acc_nxt[i] = '0;
        end else begin
          acc_nxt[i] = neg ? S32_MIN[DATA_W-1:0] : S32_MAX[DATA_W-1:0];
          ta_nxt.sat = 1'b1;
        end
      end else if (neg) begin
        if (neg_ovf) begin
          acc_nxt[i] = S32_MIN[DATA_W-1:0];
          ta_nxt.sat = 1'b1;
        end else begin
          acc_nxt[i] = negq[DATA_W-1:0];
        end
      end else begin
        if (pos_ovf) begin
          acc_nxt[i] = S32_MAX[DATA_W-1:0];
          ta_nxt.sat = 1'b1;
        end else begin
          acc_nxt[i] = quo[i][DATA_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sb: acceleration times step
  // ---------------------------------------------------------------------------
  logic                       vb_r;
  body_t                      tb_r;
  logic [LANES-1:0][PA_W-1:0] pa_r, pa_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pa_nxt[i] = PA_W'($signed(acc_r[i])) * PA_W'($signed({1'b0, ta_r.dt}));
    end
  end

  // ---------------------------------------------------------------------------
  // sc: velocity update, clamped
  // ---------------------------------------------------------------------------
  logic  vc_r;
  body_t tc_r, tc_nxt;

  always_comb begin
    sat32_t             c;
    logic signed [63:0] v64;
    logic signed [63:0] d64;
    tc_nxt = tb_r;
    for (int i = 0; i < LANES; i++) begin
      v64           = 64'($signed(tb_r.vel[i]));
      d64           = 64'($signed(pa_r[i])) >>> FRAC_BITS;
      c             = sat32(v64 + d64);
      tc_nxt.vel[i] = c.val;
      tc_nxt.sat    = tc_nxt.sat | c.sat;
    end
  end

  // ---------------------------------------------------------------------------
  // sd: velocity times step, squared speed per lane, squared threshold
  // ---------------------------------------------------------------------------
  logic                       vd_r;
  body_t                      td_r;
  logic [LANES-1:0][PA_W-1:0] pv_r, pv_nxt;
  logic [LANES-1:0][SQ_W-1:0] sq_r, sq_nxt;
  logic [RR_W-1:0]            rr_r, rr_nxt;

  always_comb begin
    logic [DATA_W-1:0] ua;
    for (int i = 0; i < LANES; i++) begin
      pv_nxt[i] = PA_W'($signed(tc_r.vel[i])) * PA_W'($signed({1'b0, tc_r.dt}));
      ua        = tc_r.vel[i][DATA_W-1] ? DATA_W'(-$signed(tc_r.vel[i])) : tc_r.vel[i];
      sq_nxt[i] = SQ_W'(ua) * SQ_W'(ua);
    end
    rr_nxt = RR_W'(rest_r) * RR_W'(rest_r);
  end

  // ---------------------------------------------------------------------------
  // se: position update, clamped; rest test on the new velocity
  // ---------------------------------------------------------------------------
  logic  ve_r;
  body_t te_r, te_nxt;
  logic  still_r, still_nxt;

  always_comb begin
    sat32_t             c;
    logic signed [63:0] p64;
    logic signed [63:0] d64;
    te_nxt = td_r;
    for (int i = 0; i < LANES; i++) begin
      p64           = 64'($signed(td_r.pos[i]));
      d64           = 64'($signed(pv_r[i])) >>> FRAC_BITS;
      c             = sat32(p64 + d64);
      te_nxt.pos[i] = c.val;
      te_nxt.sat    = te_nxt.sat | c.sat;
    end
    still_nxt = ({1'b0, sq_r[0]} + {1'b0, sq_r[1]}) < (SQ_W+1)'(rr_r);
  end

  // ---------------------------------------------------------------------------
  // sf: one wrap step per coordinate, zero velocity at rest; this is the output register
  // ---------------------------------------------------------------------------
  body_t tf_r, tf_nxt;

  always_comb begin
    logic signed [DATA_W:0] p33;
    logic signed [DATA_W:0] s33;
    tf_nxt = te_r;
    for (int i = 0; i < LANES; i++) begin
      p33 = $signed({te_r.pos[i][DATA_W-1], te_r.pos[i]});
      s33 = $signed({2'b00, size_r[i]});
      if (p33 >= s33) begin
        p33 = p33 - s33;
      end else if (p33 < 0) begin
        p33 = p33 + s33;
      end
      tf_nxt.pos[i] = p33[DATA_W-1:0];
      if (still_r) begin
        tf_nxt.vel[i] = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      va_r <= vdv;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= t1_nxt;
      t2_r    <= t1_r;
      gm2_r   <= gm2_nxt;
      t3_r    <= t3_nxt;
      gm3_r   <= gm3_nxt;
      t4_r    <= t4_nxt;
      ta_r    <= ta_nxt;
      acc_r   <= acc_nxt;
      tb_r    <= ta_r;
      pa_r    <= pa_nxt;
      tc_r    <= tc_nxt;
      td_r    <= tc_r;
      pv_r    <= pv_nxt;
      sq_r    <= sq_nxt;
      rr_r    <= rr_nxt;
      te_r    <= te_nxt;
      still_r <= still_nxt;
      tf_r    <= tf_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result channel
  // ---------------------------------------------------------------------------
  assign out_tvalid = vf_r;
  assign out_tdata  = {tf_r.frc[1], tf_r.frc[0], tf_r.vel[1], tf_r.vel[0],
                       tf_r.pos[1], tf_r.pos[0]};
  assign out_tuser  = tf_r.sat;

endmodule

// ----- rtl/core/eiw_div.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes and a shared divisor
module eiw_div #(
  parameter int FRAC_BITS = 16,
  parameter int TAG_W     = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [eiw_pkg::LANES-1:0][eiw_pkg::DATA_W-1:0] in_mag,
  input  logic [eiw_pkg::MASS_W-1:0]                   in_div,
  input  logic [TAG_W-1:0]                             in_tag,
  output logic                                         out_valid,
  output logic [eiw_pkg::LANES-1:0][eiw_pkg::DATA_W+FRAC_BITS-1:0] out_quo,
  output logic [TAG_W-1:0]                             out_tag
);
  import eiw_pkg::*;

  localparam int N_W = DATA_W + FRAC_BITS;

  logic [LANES-1:0][MASS_W-1:0] rem_r [N_W];
  logic [LANES-1:0][N_W-1:0]    dq_r  [N_W];
  logic [MASS_W-1:0]            div_r [N_W];
  logic [TAG_W-1:0]             tag_r [N_W];
  logic                         vld_r [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_stage
    logic [LANES-1:0][MASS_W-1:0] rem_pv;
    logic [LANES-1:0][N_W-1:0]    dq_pv;
    logic [MASS_W-1:0]            div_pv;
    logic [TAG_W-1:0]             tag_pv;
    logic                         vld_pv;
    logic [LANES-1:0][MASS_W-1:0] rem_nxt;
    logic [LANES-1:0][N_W-1:0]    dq_nxt;

    if (s == 0) begin : g_first
      for (genvar i = 0; i < LANES; i++) begin : g_ln
        assign rem_pv[i] = '0;
        assign dq_pv[i]  = {in_mag[i], {FRAC_BITS{1'b0}}};
      end
      assign div_pv = in_div;
      assign tag_pv = in_tag;
      assign vld_pv = in_valid;
    end else begin : g_next
      assign rem_pv = rem_r[s-1];
      assign dq_pv  = dq_r[s-1];
      assign div_pv = div_r[s-1];
      assign tag_pv = tag_r[s-1];
      assign vld_pv = vld_r[s-1];
    end

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
      logic [MASS_W:0] shifted;
      logic            ge;
      for (int i = 0; i < LANES; i++) begin
        shifted    = {rem_pv[i], dq_pv[i][N_W-1]};
        ge         = (shifted >= {1'b0, div_pv});
        rem_nxt[i] = ge ? MASS_W'(shifted - {1'b0, div_pv}) : shifted[MASS_W-1:0];
        dq_nxt[i]  = {dq_pv[i][N_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        dq_r[s]  <= dq_nxt;
        div_r[s] <= div_pv;
        tag_r[s] <= tag_pv;
      end
    end
  end

  assign out_valid = vld_r[N_W-1];
  assign out_quo   = dq_r[N_W-1];
  assign out_tag   = tag_r[N_W-1];

endmodule
